// ===== sv/escaped_command_tokenizer_top_defines.svh =====
// Assertion macros for the escaped command tokenizer.
// The bodies use the clock aclk and the reset aresetn of the module that uses them.
`ifndef ESCAPED_COMMAND_TOKENIZER_TOP_DEFINES_SVH
`define ESCAPED_COMMAND_TOKENIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ECT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ECT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECT_ASSERT_IMPL(label, ante, cons, msg)
`define ECT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/ect_pkg.sv =====
package ect_pkg;

    typedef enum logic [2:0] {
        ST_NORMAL  = 3'd0,
        ST_N_ESC   = 3'd1,
        ST_N_SPACE = 3'd2,
        ST_QUOTED  = 3'd3,
        ST_Q_ESC   = 3'd4,
        ST_DISCARD = 3'd5
    } scan_state_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [4:0] tok;
        logic [9:0] off;
        logic       err;
        logic       ovf;
        logic       last;
    } result_t;

    // results caused by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

// ===== sv/ect_step.sv =====
module ect_step #(
    parameter int MAX_TOKENS    = 32,
    parameter int MAX_TOKEN_LEN = 1024,
    parameter int TOK_W         = 6,
    parameter int OFF_W         = 11
) (
    input  logic [7:0]           in_char,
    input  ect_pkg::scan_state_t state_i,
    input  logic                 abp_i,
    input  logic [TOK_W-1:0]     tok_i,
    input  logic [OFF_W-1:0]     off_i,
    input  logic                 drop_i,
    output ect_pkg::scan_state_t state_o,
    output logic                 abp_o,
    output logic [TOK_W-1:0]     tok_o,
    output logic [OFF_W-1:0]     off_o,
    output logic                 drop_o,
    output ect_pkg::step_out_t   res_o
);

    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_CHAR = 2'd1,
        EM_END  = 2'd2
    } emit_t;

    localparam logic [TOK_W-1:0] MAX_T  = TOK_W'(MAX_TOKENS);
    localparam logic [TOK_W-1:0] LAST_T = TOK_W'(MAX_TOKENS - 1);
    localparam logic [OFF_W-1:0] LEN_T  = OFF_W'(MAX_TOKEN_LEN);

    function automatic ect_pkg::result_t mk_res(logic kind, logic [7:0] ch,
                                                logic [31:0] tok, logic [31:0] off,
                                                logic err, logic ovf);
        ect_pkg::result_t r;
        r.kind = kind;
        r.ch   = ch;
        r.tok  = tok[4:0];
        r.off  = off[9:0];
        r.err  = err;
        r.ovf  = ovf;
        r.last = 1'b0;
        return r;
    endfunction

    // escape decode
    logic       esc_known;
    logic       esc_two;
    logic [7:0] esc_char;

    always_comb begin
        esc_known = 1'b1;
        esc_two   = 1'b0;
        esc_char  = in_char;
        case (in_char)
            ect_pkg::CH_N:      esc_char = ect_pkg::CH_LF;
            ect_pkg::CH_T:      esc_char = ect_pkg::CH_TAB;
            ect_pkg::CH_QUOTE:  esc_char = ect_pkg::CH_QUOTE;
            ect_pkg::CH_BSLASH: esc_char = ect_pkg::CH_BSLASH;
            ect_pkg::CH_STAR: begin
                esc_two  = 1'b1;
                esc_char = ect_pkg::CH_STAR;
            end
            default:            esc_known = 1'b0;
        endcase
    end

    // plain byte outside quotes
    emit_t                nb_kind;
    ect_pkg::scan_state_t nb_state;

    always_comb begin
        nb_kind  = EM_NONE;
        nb_state = ect_pkg::ST_NORMAL;
        case (in_char)
            ect_pkg::CH_NUL:    nb_kind  = EM_END;
            ect_pkg::CH_BSLASH: nb_state = ect_pkg::ST_N_ESC;
            ect_pkg::CH_SPACE:  nb_state = ect_pkg::ST_N_SPACE;
            default:            nb_kind  = EM_CHAR;
        endcase
    end

    // plan: optional token open, optional backslash, then char or end
    logic                 pre_new;
    logic                 a_valid;
    emit_t                b_kind;
    logic [7:0]           b_char;
    logic                 b_err;
    ect_pkg::scan_state_t plan_state;
    logic                 plan_abp;

    always_comb begin
        pre_new    = 1'b0;
        a_valid    = 1'b0;
        b_kind     = EM_NONE;
        b_char     = in_char;
        b_err      = 1'b0;
        plan_state = ect_pkg::ST_NORMAL;
        plan_abp   = abp_i;
        unique case (state_i)
            ect_pkg::ST_N_ESC: begin
                if (esc_known) begin
                    a_valid = esc_two;
                    b_kind  = EM_CHAR;
                    b_char  = esc_char;
                end else begin
                    a_valid    = 1'b1;
                    b_kind     = nb_kind;
                    plan_state = nb_state;
                end
            end
            ect_pkg::ST_N_SPACE: begin
                pre_new = 1'b1;
                if (in_char == ect_pkg::CH_QUOTE) begin
                    plan_state = ect_pkg::ST_QUOTED;
                    plan_abp   = 1'b0;
                end else begin
                    b_kind     = nb_kind;
                    plan_state = nb_state;
                end
            end
            ect_pkg::ST_QUOTED: begin
                plan_state = ect_pkg::ST_QUOTED;
                if (in_char == ect_pkg::CH_NUL) begin
                    b_kind = EM_END;
                    b_err  = 1'b1;
                end else if (in_char == ect_pkg::CH_QUOTE && !abp_i) begin
                    plan_state = ect_pkg::ST_DISCARD;
                end else if (in_char == ect_pkg::CH_BSLASH) begin
                    plan_state = ect_pkg::ST_Q_ESC;
                    plan_abp   = 1'b0;
                end else begin
                    b_kind   = EM_CHAR;
                    plan_abp = 1'b0;
                end
            end
            ect_pkg::ST_Q_ESC: begin
                plan_state = ect_pkg::ST_QUOTED;
                if (esc_known) begin
                    a_valid  = esc_two;
                    b_kind   = EM_CHAR;
                    b_char   = esc_char;
                    plan_abp = (in_char == ect_pkg::CH_BSLASH);
                end else begin
                    a_valid  = 1'b1;
                    plan_abp = 1'b0;
                    if (in_char == ect_pkg::CH_NUL) begin
                        b_kind = EM_END;
                        b_err  = 1'b1;
                    end else begin
                        b_kind = EM_CHAR;
                    end
                end
            end
            ect_pkg::ST_DISCARD: begin
                if (in_char == ect_pkg::CH_NUL) begin
                    b_kind = EM_END;
                    b_err  = 1'b1;
                end else begin
                    pre_new = 1'b1;
                end
            end
            default: begin
                b_kind     = nb_kind;
                plan_state = nb_state;
            end
        endcase
    end

    // carry out the plan
    logic [TOK_W-1:0] tok1;
    logic [OFF_W-1:0] off1;
    logic             drop1;
    logic [1:0]       n;
    ect_pkg::result_t r0;
    ect_pkg::result_t r1;
    ect_pkg::result_t rb;
    logic [TOK_W-1:0] tok_end;

    always_comb begin
        tok1    = tok_i;
        off1    = off_i;
        drop1   = drop_i;
        n       = 2'd0;
        r0      = '0;
        r1      = '0;
        rb      = '0;
        tok_end = (tok_i > LAST_T) ? LAST_T : tok_i;
        state_o = plan_state;
        abp_o   = plan_abp;

        if (pre_new) begin
            if (tok1 < MAX_T) begin
                tok1 = tok1 + TOK_W'(1);
                if (tok1 >= MAX_T) begin
                    drop1 = 1'b1;
                end
            end
            off1 = '0;
        end

        if (a_valid) begin
            if (tok1 >= MAX_T || off1 >= LEN_T) begin
                drop1 = 1'b1;
            end else begin
                r0   = mk_res(ect_pkg::KIND_CHAR, ect_pkg::CH_BSLASH, 32'(tok1), 32'(off1),
                              1'b0, 1'b0);
                n    = 2'd1;
                off1 = off1 + OFF_W'(1);
            end
        end

        if (b_kind == EM_CHAR) begin
            if (tok1 >= MAX_T || off1 >= LEN_T) begin
                drop1 = 1'b1;
            end else begin
                rb   = mk_res(ect_pkg::KIND_CHAR, b_char, 32'(tok1), 32'(off1), 1'b0, 1'b0);
                off1 = off1 + OFF_W'(1);
                if (n == 2'd0) begin
                    r0 = rb;
                end else begin
                    r1 = rb;
                end
                n = n + 2'd1;
            end
        end else if (b_kind == EM_END) begin
            tok_end = (tok1 > LAST_T) ? LAST_T : tok1;
            rb      = mk_res(ect_pkg::KIND_END, ect_pkg::CH_NUL, 32'(tok_end), 32'd0,
                             b_err, drop1);
            if (n == 2'd0) begin
                r0 = rb;
            end else begin
                r1 = rb;
            end
            n       = n + 2'd1;
            tok1    = '0;
            off1    = '0;
            drop1   = 1'b0;
            state_o = ect_pkg::ST_NORMAL;
            abp_o   = 1'b0;
        end

        if (n == 2'd2) begin
            r1.last = 1'b1;
        end else if (n == 2'd1) begin
            r0.last = 1'b1;
        end

        tok_o        = tok1;
        off_o        = off1;
        drop_o       = drop1;
        res_o.count  = n;
        res_o.r0     = r0;
        res_o.r1     = r1;
    end

endmodule

// ===== sv/ect_out_buf.sv =====
`include "escaped_command_tokenizer_top_defines.svh"

module ect_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ect_pkg::step_out_t push_data,
    output logic               push_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ect_pkg::result_t   head
);

    ect_pkg::result_t slot0_reg;
    ect_pkg::result_t slot0_next;
    ect_pkg::result_t slot1_reg;
    ect_pkg::result_t slot1_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign m_valid    = (count_reg != 2'd0);
    assign pop        = m_valid && m_ready;
    // a new request lands only once the buffer drains to empty this cycle
    assign push_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign head       = slot0_reg;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && push_ready) begin
            slot0_next = push_data.r0;
            slot1_next = push_data.r1;
            count_next = push_data.count;
        end else if (pop) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `ECT_ASSERT_IMPL(a_count_range, 1'b1, count_reg != 2'd3, "result count out of range")
    `ECT_ASSERT_NEXT(a_pop_full, pop && count_reg == 2'd2, count_reg == 2'd1, "pop from full lost")
    `ECT_ASSERT_NEXT(a_push_count, push && push_ready, count_reg == $past(push_data.count), "push count wrong")
    `ECT_ASSERT_IMPL(a_head_last, count_reg == 2'd1, slot0_reg.last, "single held result not last")

endmodule

// ===== sv/escaped_command_tokenizer_top.sv =====
// channel | dir | tdata                                   | tuser     | tlast
// s_      | in  | [7:0] in_char                           | -         | -
// m_      | out | [7:0] out_char, [12:8] token_number,    | item_kind | last_of_run
//         |     | [22:13] char_offset, [23] open_quote_error, [24] overflow_seen
//
// One input byte per cycle while s_tready is high; a byte causes 0, 1 or 2 results.
// A byte with two results holds s_tready low while the
// two-entry result buffer drains; that buffer sets the rate.
// Results of a taken byte are registered in the buffer and valid the cycle after it is taken.
// aresetn is synchronous, active low; it clears scan state and the buffer.
// Stalls on m_tready hold the buffer; input is taken once it can empty.
`include "escaped_command_tokenizer_top_defines.svh"

module escaped_command_tokenizer_top #(
    parameter int MAX_TOKENS    = 32,
    parameter int MAX_TOKEN_LEN = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_char, token_number, char_offset, open_quote_error,
                                   // overflow_seen, zero pad
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // last_of_run
);

    localparam int TOK_W = $clog2(MAX_TOKENS + 1);
    localparam int OFF_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [TOK_W-1:0] MAX_T = TOK_W'(MAX_TOKENS);
    localparam logic [OFF_W-1:0] LEN_T = OFF_W'(MAX_TOKEN_LEN);

    ect_pkg::scan_state_t scan_state_reg;
    ect_pkg::scan_state_t scan_state_next;
    logic                 abp_reg;
    logic                 abp_next;
    logic [TOK_W-1:0]     tok_reg;
    logic [TOK_W-1:0]     tok_next;
    logic [OFF_W-1:0]     off_reg;
    logic [OFF_W-1:0]     off_next;
    logic                 drop_reg;
    logic                 drop_next;

    ect_pkg::step_out_t   step_res;
    ect_pkg::result_t     head;
    logic                 accept;
    logic                 end_seen;

    assign accept   = s_tvalid && s_tready;
    assign end_seen = (step_res.count == 2'd1 && step_res.r0.kind == ect_pkg::KIND_END)
                   || (step_res.count == 2'd2 && step_res.r1.kind == ect_pkg::KIND_END);

    ect_step #(
        .MAX_TOKENS   (MAX_TOKENS),
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .TOK_W        (TOK_W),
        .OFF_W        (OFF_W)
    ) u_step (
        .in_char(s_tdata),
        .state_i(scan_state_reg),
        .abp_i  (abp_reg),
        .tok_i  (tok_reg),
        .off_i  (off_reg),
        .drop_i (drop_reg),
        .state_o(scan_state_next),
        .abp_o  (abp_next),
        .tok_o  (tok_next),
        .off_o  (off_next),
        .drop_o (drop_next),
        .res_o  (step_res)
    );

    ect_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (step_res),
        .push_ready(s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .head      (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_state_reg <= ect_pkg::ST_NORMAL;
            abp_reg        <= 1'b0;
            tok_reg        <= '0;
            off_reg        <= '0;
            drop_reg       <= 1'b0;
        end else if (accept) begin
            scan_state_reg <= scan_state_next;
            abp_reg        <= abp_next;
            tok_reg        <= tok_next;
            off_reg        <= off_next;
            drop_reg       <= drop_next;
        end
    end

    assign m_tdata = {7'b0, head.ovf, head.err, head.off, head.tok, head.ch};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `ECT_ASSERT_NEXT(a_end_clears, accept && end_seen,
                     scan_state_reg == ect_pkg::ST_NORMAL && tok_reg == '0
                     && off_reg == '0 && !drop_reg, "end did not clear state")
    `ECT_ASSERT_IMPL(a_tok_bound, 1'b1, tok_reg <= MAX_T, "token count past limit")
    `ECT_ASSERT_IMPL(a_off_bound, 1'b1, off_reg <= LEN_T, "offset past limit")

endmodule
